// ===== src/uv_sphere_vertex_generator_core_macros.svh =====
// Assertion macros for the vertex generator.
`ifndef UV_SPHERE_VERTEX_GENERATOR_CORE_MACROS_SVH
`define UV_SPHERE_VERTEX_GENERATOR_CORE_MACROS_SVH

`ifndef SYNTH
`define UVS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define UVS_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define UVS_ASSERT(label, prop, msg)
`define UVS_NEVER(label, expr, msg)
`endif

`endif

// ===== src/uvs_pkg.sv =====
`default_nettype none
package uvs_pkg;

    localparam int MAX_LOG2_COUNT_DEF = 10;
    localparam int UNIT_FRAC_BITS_DEF = 14;

    localparam int IDX_W     = 11;
    localparam int LOG2_W    = 4;
    localparam int RAD_W     = 16;
    localparam int POS_W     = 17;
    localparam int NORM_W    = 16;
    localparam int TEX_W     = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_LOG2_SECTORS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOG2_STACKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 2'd2;

    localparam logic [LOG2_W-1:0] LOG2_RESET   = 4'd8;
    localparam logic [RAD_W-1:0]  RADIUS_RESET = 16'd4096;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned Q30_ONE     = 64'd1 << 30;

    typedef struct packed {
        logic ang;
        logic rom;
        logic quad;
        logic mul_a;
        logic mul_b;
        logic out;
    } stage_en_t;

    // Base-quadrant sin (upper word) and cos (lower word), Q1.frac, for offset r.
    function automatic logic [63:0] trig_entry(input int unsigned r, input int unsigned rbits,
                                               input int unsigned frac);
        longint unsigned x, x2, ts, tc, sub, sv, cv, half;
        int unsigned sh;
        sh   = 30 - frac;
        half = 64'd1 << (sh - 1);
        x    = (longint'(r) * HALF_PI_Q30) >> rbits;
        x2   = (x * x) >> 30;
        ts   = Q30_ONE;
        tc   = Q30_ONE;
        sub = ((x2 * ts) >> 30) / 64'd156; ts = (sub > Q30_ONE) ? 64'd0 : Q30_ONE - sub;
        sub = ((x2 * tc) >> 30) / 64'd132; tc = (sub > Q30_ONE) ? 64'd0 : Q30_ONE - sub;
        sub = ((x2 * ts) >> 30) / 64'd110; ts = (sub > Q30_ONE) ? 64'd0 : Q30_ONE - sub;
        sub = ((x2 * tc) >> 30) / 64'd90;  tc = (sub > Q30_ONE) ? 64'd0 : Q30_ONE - sub;
        sub = ((x2 * ts) >> 30) / 64'd72;  ts = (sub > Q30_ONE) ? 64'd0 : Q30_ONE - sub;
        sub = ((x2 * tc) >> 30) / 64'd56;  tc = (sub > Q30_ONE) ? 64'd0 : Q30_ONE - sub;
        sub = ((x2 * ts) >> 30) / 64'd42;  ts = (sub > Q30_ONE) ? 64'd0 : Q30_ONE - sub;
        sub = ((x2 * tc) >> 30) / 64'd30;  tc = (sub > Q30_ONE) ? 64'd0 : Q30_ONE - sub;
        sub = ((x2 * ts) >> 30) / 64'd20;  ts = (sub > Q30_ONE) ? 64'd0 : Q30_ONE - sub;
        sub = ((x2 * tc) >> 30) / 64'd12;  tc = (sub > Q30_ONE) ? 64'd0 : Q30_ONE - sub;
        sub = ((x2 * ts) >> 30) / 64'd6;   ts = (sub > Q30_ONE) ? 64'd0 : Q30_ONE - sub;
        sub = ((x2 * tc) >> 30) / 64'd2;   tc = (sub > Q30_ONE) ? 64'd0 : Q30_ONE - sub;
        sv = ((((x * ts) >> 30)) + half) >> sh;
        cv = (tc + half) >> sh;
        return {sv[31:0], cv[31:0]};
    endfunction

    // Arithmetic shift right, round to nearest, ties away from zero.
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                       input int unsigned sh);
        logic [63:0] mag, res;
        mag = v[63] ? 64'(-v) : 64'(v);
        res = (mag + (64'd1 << (sh - 1))) >> sh;
        return v[63] ? -$signed(res) : $signed(res);
    endfunction

endpackage
`default_nettype wire

// ===== src/uvs_angle.sv =====
`default_nettype none
module uvs_angle #(
    parameter int MAX_LOG2_COUNT = uvs_pkg::MAX_LOG2_COUNT_DEF,
    localparam int P  = MAX_LOG2_COUNT + 1,
    localparam int RW = P - 2
) (
    input  wire logic                            clk,
    input  wire uvs_pkg::stage_en_t              en,
    input  wire logic [uvs_pkg::LOG2_W-1:0]      log2_sectors,
    input  wire logic [uvs_pkg::LOG2_W-1:0]      log2_stacks,
    input  wire logic [uvs_pkg::IDX_W-1:0]       stack_index,
    input  wire logic [uvs_pkg::IDX_W-1:0]       sector_index,
    output logic [1:0]                           quad_st,
    output logic [RW-1:0]                        r_st,
    output logic [1:0]                           quad_se,
    output logic [RW-1:0]                        r_se,
    output logic [uvs_pkg::TEX_W-1:0]            tex_u,
    output logic [uvs_pkg::TEX_W-1:0]            tex_v
);
    localparam int CW = (P > uvs_pkg::IDX_W) ? P : uvs_pkg::IDX_W;
    localparam int LW = uvs_pkg::LOG2_W;

    logic [LW-1:0] lc, ls;
    logic [CW-1:0] cnt_c, cnt_s, i_sat, j_sat;
    logic [P-1:0]  st_phase, se_phase, quarter;
    logic [uvs_pkg::TEX_W-1:0] u_next, v_next;

    logic [1:0]    quad_st_reg, quad_se_reg;
    logic [RW-1:0] r_st_reg, r_se_reg;
    logic [uvs_pkg::TEX_W-1:0] tex_u_reg, tex_v_reg;

    always_comb
    begin
        lc = (log2_sectors < LW'(2)) ? LW'(2) :
             (log2_sectors > LW'(MAX_LOG2_COUNT)) ? LW'(MAX_LOG2_COUNT) : log2_sectors;
        ls = (log2_stacks < LW'(2)) ? LW'(2) :
             (log2_stacks > LW'(MAX_LOG2_COUNT)) ? LW'(MAX_LOG2_COUNT) : log2_stacks;
        cnt_c = CW'(1) << lc;
        cnt_s = CW'(1) << ls;
        i_sat = (CW'(stack_index) > cnt_s) ? cnt_s : CW'(stack_index);
        j_sat = (CW'(sector_index) > cnt_c) ? cnt_c : CW'(sector_index);
        quarter  = {2'b01, {RW{1'b0}}};
        st_phase = quarter - (i_sat[P-1:0] << (LW'(MAX_LOG2_COUNT) - ls));
        se_phase = j_sat[P-1:0] << (LW'(P) - lc);
        u_next = uvs_pkg::TEX_W'(j_sat) << (5'd16 - {1'b0, lc});
        v_next = uvs_pkg::TEX_W'(i_sat) << (5'd16 - {1'b0, ls});
    end

    always_ff @(posedge clk)
    begin
        if (en.ang)
        begin
            quad_st_reg <= st_phase[P-1:P-2];
            r_st_reg    <= st_phase[RW-1:0];
            quad_se_reg <= se_phase[P-1:P-2];
            r_se_reg    <= se_phase[RW-1:0];
            tex_u_reg   <= u_next;
            tex_v_reg   <= v_next;
        end
    end

    assign quad_st = quad_st_reg;
    assign r_st    = r_st_reg;
    assign quad_se = quad_se_reg;
    assign r_se    = r_se_reg;
    assign tex_u   = tex_u_reg;
    assign tex_v   = tex_v_reg;
endmodule
`default_nettype wire

// ===== src/uvs_trig.sv =====
`default_nettype none
module uvs_trig #(
    parameter int MAX_LOG2_COUNT = uvs_pkg::MAX_LOG2_COUNT_DEF,
    parameter int UNIT_FRAC_BITS = uvs_pkg::UNIT_FRAC_BITS_DEF,
    localparam int RW = MAX_LOG2_COUNT - 1,
    localparam int SW = UNIT_FRAC_BITS + 2
) (
    input  wire logic               clk,
    input  wire uvs_pkg::stage_en_t en,
    input  wire logic [1:0]         quad_st,
    input  wire logic [RW-1:0]      r_st,
    input  wire logic [1:0]         quad_se,
    input  wire logic [RW-1:0]      r_se,
    output logic signed [SW-1:0]    s_st,
    output logic signed [SW-1:0]    c_st,
    output logic signed [SW-1:0]    s_se,
    output logic signed [SW-1:0]    c_se
);
    localparam int TW    = UNIT_FRAC_BITS + 1;
    localparam int DEPTH = 1 << RW;

    logic [2*TW-1:0] rom [DEPTH];

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_rom
        localparam logic [63:0] ENTRY = uvs_pkg::trig_entry(g, RW, UNIT_FRAC_BITS);
        assign rom[g] = {ENTRY[32+TW-1:32], ENTRY[TW-1:0]};
    end

    logic [2*TW-1:0] st_word_reg, se_word_reg;
    logic [1:0]      quad_st_reg, quad_se_reg;
    logic signed [SW-1:0] s_st_next, c_st_next, s_se_next, c_se_next;
    logic signed [SW-1:0] s_st_reg, c_st_reg, s_se_reg, c_se_reg;

    always_ff @(posedge clk)
    begin
        if (en.rom)
        begin
            st_word_reg <= rom[r_st];
            se_word_reg <= rom[r_se];
            quad_st_reg <= quad_st;
            quad_se_reg <= quad_se;
        end
    end

    function automatic logic signed [2*SW-1:0] fold(input logic [1:0] q,
                                                    input logic [2*TW-1:0] w);
        logic signed [SW-1:0] s0, c0, sn, cs;
        s0 = $signed({1'b0, w[2*TW-1:TW]});
        c0 = $signed({1'b0, w[TW-1:0]});
        case (q)
            2'd0:    begin sn = s0;  cs = c0;  end
            2'd1:    begin sn = c0;  cs = -s0; end
            2'd2:    begin sn = -s0; cs = -c0; end
            default: begin sn = -c0; cs = s0;  end
        endcase
        return {sn, cs};
    endfunction

    always_comb
    begin
        {s_st_next, c_st_next} = fold(quad_st_reg, st_word_reg);
        {s_se_next, c_se_next} = fold(quad_se_reg, se_word_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en.quad)
        begin
            s_st_reg <= s_st_next;
            c_st_reg <= c_st_next;
            s_se_reg <= s_se_next;
            c_se_reg <= c_se_next;
        end
    end

    assign s_st = s_st_reg;
    assign c_st = c_st_reg;
    assign s_se = s_se_reg;
    assign c_se = c_se_reg;
endmodule
`default_nettype wire

// ===== src/uvs_mult.sv =====
`default_nettype none
module uvs_mult #(
    parameter int UNIT_FRAC_BITS = uvs_pkg::UNIT_FRAC_BITS_DEF,
    localparam int SW = UNIT_FRAC_BITS + 2
) (
    input  wire logic                              clk,
    input  wire uvs_pkg::stage_en_t                en,
    input  wire logic [uvs_pkg::RAD_W-1:0]         radius,
    input  wire logic signed [SW-1:0]              s_st,
    input  wire logic signed [SW-1:0]              c_st,
    input  wire logic signed [SW-1:0]              s_se,
    input  wire logic signed [SW-1:0]              c_se,
    output logic signed [uvs_pkg::POS_W-1:0]       pos_x,
    output logic signed [uvs_pkg::POS_W-1:0]       pos_y,
    output logic signed [uvs_pkg::POS_W-1:0]       pos_z,
    output logic signed [uvs_pkg::NORM_W-1:0]      norm_x,
    output logic signed [uvs_pkg::NORM_W-1:0]      norm_y,
    output logic signed [uvs_pkg::NORM_W-1:0]      norm_z,
    output logic signed [uvs_pkg::POS_W-1:0]       tang_x,
    output logic signed [uvs_pkg::POS_W-1:0]       tang_z
);
    localparam int F  = UNIT_FRAC_BITS;
    localparam int PW = 2 * SW;
    localparam int AW = uvs_pkg::RAD_W + 1 + SW;
    localparam int XW = AW + SW;

    logic signed [uvs_pkg::RAD_W:0] rad_s;
    assign rad_s = $signed({1'b0, radius});

    // stage A
    logic signed [PW-1:0] cs_reg, cc_reg;
    logic signed [AW-1:0] rs_st_reg, rc_se_reg, rs_se_reg, rc_st_reg;
    logic signed [SW-1:0] s_st_a_reg, s_se_a_reg, c_se_a_reg;
    // stage B
    logic signed [XW-1:0] px_reg, pz_reg;
    logic signed [PW-1:0] cs_b_reg, cc_b_reg;
    logic signed [AW-1:0] rs_st_b_reg, rc_se_b_reg, rs_se_b_reg;
    logic signed [SW-1:0] s_st_b_reg;
    // output
    logic signed [uvs_pkg::POS_W-1:0]  pos_x_reg, pos_y_reg, pos_z_reg, tang_x_reg, tang_z_reg;
    logic signed [uvs_pkg::NORM_W-1:0] norm_x_reg, norm_y_reg, norm_z_reg;

    always_ff @(posedge clk)
    begin
        if (en.mul_a)
        begin
            cs_reg     <= PW'(c_st) * PW'(s_se);
            cc_reg     <= PW'(c_st) * PW'(c_se);
            rs_st_reg  <= AW'(rad_s) * AW'(s_st);
            rc_se_reg  <= AW'(rad_s) * AW'(c_se);
            rs_se_reg  <= AW'(rad_s) * AW'(s_se);
            rc_st_reg  <= AW'(rad_s) * AW'(c_st);
            s_st_a_reg <= s_st;
            s_se_a_reg <= s_se;
            c_se_a_reg <= c_se;
        end
        if (en.mul_b)
        begin
            px_reg      <= XW'(rc_st_reg) * XW'(s_se_a_reg);
            pz_reg      <= XW'(rc_st_reg) * XW'(c_se_a_reg);
            cs_b_reg    <= cs_reg;
            cc_b_reg    <= cc_reg;
            rs_st_b_reg <= rs_st_reg;
            rc_se_b_reg <= rc_se_reg;
            rs_se_b_reg <= rs_se_reg;
            s_st_b_reg  <= s_st_a_reg;
        end
        if (en.out)
        begin
            pos_x_reg  <= uvs_pkg::POS_W'(uvs_pkg::round_shift(64'(px_reg), 2 * F));
            pos_y_reg  <= uvs_pkg::POS_W'(uvs_pkg::round_shift(64'(rs_st_b_reg), F));
            pos_z_reg  <= uvs_pkg::POS_W'(uvs_pkg::round_shift(64'(pz_reg), 2 * F));
            norm_x_reg <= uvs_pkg::NORM_W'(uvs_pkg::round_shift(64'(cs_b_reg), F));
            norm_y_reg <= uvs_pkg::NORM_W'(s_st_b_reg);
            norm_z_reg <= uvs_pkg::NORM_W'(uvs_pkg::round_shift(64'(cc_b_reg), F));
            tang_x_reg <= uvs_pkg::POS_W'(uvs_pkg::round_shift(64'(rc_se_b_reg), F));
            tang_z_reg <= uvs_pkg::POS_W'(-uvs_pkg::round_shift(64'(rs_se_b_reg), F));
        end
    end

    assign pos_x  = pos_x_reg;
    assign pos_y  = pos_y_reg;
    assign pos_z  = pos_z_reg;
    assign norm_x = norm_x_reg;
    assign norm_y = norm_y_reg;
    assign norm_z = norm_z_reg;
    assign tang_x = tang_x_reg;
    assign tang_z = tang_z_reg;
endmodule
`default_nettype wire

// ===== src/uv_sphere_vertex_generator_core.sv =====
// Channel   Handshake              Beat contents
// config    cfg_we                 cfg_index, cfg_data
// input     in_valid / in_ready    stack_index, sector_index
// output    out_valid / out_ready  pos_*, norm_*, tang_x, tang_z, tex_u, tex_v
//
// One beat per cycle sustained while out_ready is high; the stages are angle, trig ROM read,
// quadrant fold, two multiply stages and rounding/output register.
// Each stage holds its own valid bit and moves when the next one is free,
// so bubbles close up and a stall at the output backs up stage by stage.
// Reset clears the valid bits and loads the register reset values.
`default_nettype none
`include "uv_sphere_vertex_generator_core_macros.svh"
module uv_sphere_vertex_generator_core #(
    parameter int MAX_LOG2_COUNT = uvs_pkg::MAX_LOG2_COUNT_DEF,
    parameter int UNIT_FRAC_BITS = uvs_pkg::UNIT_FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [uvs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [uvs_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [uvs_pkg::IDX_W-1:0]         stack_index,
    input  wire logic [uvs_pkg::IDX_W-1:0]         sector_index,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [uvs_pkg::POS_W-1:0]       pos_x,
    output logic signed [uvs_pkg::POS_W-1:0]       pos_y,
    output logic signed [uvs_pkg::POS_W-1:0]       pos_z,
    output logic signed [uvs_pkg::NORM_W-1:0]      norm_x,
    output logic signed [uvs_pkg::NORM_W-1:0]      norm_y,
    output logic signed [uvs_pkg::NORM_W-1:0]      norm_z,
    output logic signed [uvs_pkg::POS_W-1:0]       tang_x,
    output logic signed [uvs_pkg::POS_W-1:0]       tang_z,
    output logic [uvs_pkg::TEX_W-1:0]              tex_u,
    output logic [uvs_pkg::TEX_W-1:0]              tex_v
);
    localparam int RW = MAX_LOG2_COUNT - 1;
    localparam int SW = UNIT_FRAC_BITS + 2;
    localparam int NST = 6;

    logic [uvs_pkg::LOG2_W-1:0] log2_sectors_reg, log2_stacks_reg;
    logic [uvs_pkg::RAD_W-1:0]  radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log2_sectors_reg <= uvs_pkg::LOG2_RESET;
            log2_stacks_reg  <= uvs_pkg::LOG2_RESET;
            radius_reg       <= uvs_pkg::RADIUS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                uvs_pkg::REG_LOG2_SECTORS: log2_sectors_reg <= cfg_data[uvs_pkg::LOG2_W-1:0];
                uvs_pkg::REG_LOG2_STACKS:  log2_stacks_reg  <= cfg_data[uvs_pkg::LOG2_W-1:0];
                uvs_pkg::REG_RADIUS:       radius_reg       <= cfg_data[uvs_pkg::RAD_W-1:0];
                default: ;
            endcase
        end
    end

    logic [NST-1:0] v_reg, v_next, en_vec;
    uvs_pkg::stage_en_t en;

    always_comb
    begin
        en_vec[NST-1] = !v_reg[NST-1] || out_ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            en_vec[k] = !v_reg[k] || en_vec[k+1];
        end
        v_next[0] = en_vec[0] ? in_valid : v_reg[0];
        for (int k = 1; k < NST; k++)
        begin
            if (en_vec[k])
                v_next[k] = v_reg[k-1];
            else
                v_next[k] = v_reg[k];
        end
    end

    assign en = '{ang: en_vec[0], rom: en_vec[1], quad: en_vec[2],
                  mul_a: en_vec[3], mul_b: en_vec[4], out: en_vec[5]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    logic [1:0]    quad_st, quad_se;
    logic [RW-1:0] r_st, r_se;
    logic [uvs_pkg::TEX_W-1:0] tex_u_a, tex_v_a;
    logic signed [SW-1:0] s_st, c_st, s_se, c_se;

    uvs_angle #(
        .MAX_LOG2_COUNT(MAX_LOG2_COUNT)
    ) u_angle (
        .clk          (clk),
        .en           (en),
        .log2_sectors (log2_sectors_reg),
        .log2_stacks  (log2_stacks_reg),
        .stack_index  (stack_index),
        .sector_index (sector_index),
        .quad_st      (quad_st),
        .r_st         (r_st),
        .quad_se      (quad_se),
        .r_se         (r_se),
        .tex_u        (tex_u_a),
        .tex_v        (tex_v_a)
    );

    uvs_trig #(
        .MAX_LOG2_COUNT(MAX_LOG2_COUNT),
        .UNIT_FRAC_BITS(UNIT_FRAC_BITS)
    ) u_trig (
        .clk     (clk),
        .en      (en),
        .quad_st (quad_st),
        .r_st    (r_st),
        .quad_se (quad_se),
        .r_se    (r_se),
        .s_st    (s_st),
        .c_st    (c_st),
        .s_se    (s_se),
        .c_se    (c_se)
    );

    uvs_mult #(
        .UNIT_FRAC_BITS(UNIT_FRAC_BITS)
    ) u_mult (
        .clk    (clk),
        .en     (en),
        .radius (radius_reg),
        .s_st   (s_st),
        .c_st   (c_st),
        .s_se   (s_se),
        .c_se   (c_se),
        .pos_x  (pos_x),
        .pos_y  (pos_y),
        .pos_z  (pos_z),
        .norm_x (norm_x),
        .norm_y (norm_y),
        .norm_z (norm_z),
        .tang_x (tang_x),
        .tang_z (tang_z)
    );

    // texture coordinates ride alongside the trig/multiply stages
    logic [uvs_pkg::TEX_W-1:0] tex_u_reg [1:NST-1];
    logic [uvs_pkg::TEX_W-1:0] tex_v_reg [1:NST-1];

    always_ff @(posedge clk)
    begin
        if (en_vec[1])
        begin
            tex_u_reg[1] <= tex_u_a;
            tex_v_reg[1] <= tex_v_a;
        end
        for (int k = 2; k < NST; k++)
        begin
            if (en_vec[k])
            begin
                tex_u_reg[k] <= tex_u_reg[k-1];
                tex_v_reg[k] <= tex_v_reg[k-1];
            end
        end
    end

    assign tex_u     = tex_u_reg[NST-1];
    assign tex_v     = tex_v_reg[NST-1];
    assign out_valid = v_reg[NST-1];
    assign in_ready  = en_vec[0];

    `UVS_ASSERT(a_accept_fills, in_valid && in_ready |=> v_reg[0], "accepted beat lost at entry")
    `UVS_ASSERT(a_full_stall, (&v_reg) && !out_ready |-> !in_ready, "ready while pipe full and stalled")
    `UVS_ASSERT(a_hold_last, v_reg[NST-1] && !out_ready |=> v_reg[NST-1] && $stable(tex_u), "output beat dropped")
    `UVS_NEVER(a_tex_range, out_valid && (tex_u > 17'h10000 || tex_v > 17'h10000), "tex beyond one")
endmodule
`default_nettype wire
